### sv/wbd_pkg.sv
`default_nettype none

package wbd_pkg;

   // Field and state widths
   localparam int RAW_W    = 10;
   localparam int FACTOR_W = 16;
   localparam int THRESH_W = 16;
   localparam int AVG_W    = 26;
   localparam int FRAC_W   = 16;
   localparam int BP_W     = 11;
   localparam int DIFF_W   = 12;
   localparam int WSUM_W   = 16;
   localparam int EVENT_W  = 2;

   // Control register port
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam csr_addr_type CSR_SLOW_FACTOR     = 2'd0;
   localparam csr_addr_type CSR_FAST_FACTOR     = 2'd1;
   localparam csr_addr_type CSR_START_THRESHOLD = 2'd2;
   localparam csr_addr_type CSR_END_THRESHOLD   = 2'd3;

   // Reset values of the control registers
   localparam logic [FACTOR_W-1:0]        SLOW_FACTOR_RST     = 16'd64880;
   localparam logic [FACTOR_W-1:0]        FAST_FACTOR_RST     = 16'd58982;
   localparam logic signed [THRESH_W-1:0] START_THRESHOLD_RST = -16'sd10;
   localparam logic signed [THRESH_W-1:0] END_THRESHOLD_RST   = -16'sd2;

   // Event codes on the response
   typedef logic [EVENT_W-1:0] event_type;

   localparam event_type EV_NONE  = 2'd0;
   localparam event_type EV_BEGIN = 2'd1;
   localparam event_type EV_END   = 2'd2;

endpackage

`default_nettype wire

### sv/wbd_ema.sv
`default_nettype none

// One exponential average step:
// avg' = ((avg * f) >> 16) + raw * (65536 - f), kept to 26 bits.
// The sample term is already at the average's scale, so the shift only touches the product.
module wbd_ema
   import wbd_pkg::*;
(
   input  wire logic [AVG_W-1:0]    avg,
   input  wire logic [FACTOR_W-1:0] factor,
   input  wire logic [RAW_W-1:0]    raw,
   output logic      [AVG_W-1:0]    avg_next
);

   logic [AVG_W+FACTOR_W-1:0]   keep;
   logic [FACTOR_W:0]           weight;
   logic [RAW_W+FACTOR_W:0]     add;

   assign keep     = avg * factor;
   assign weight   = (FACTOR_W+1)'(1 << FRAC_W) - {1'b0, factor};
   assign add      = raw * weight;
   assign avg_next = keep[AVG_W+FACTOR_W-1:FRAC_W] + add[AVG_W-1:0];

endmodule

`default_nettype wire

### sv/wind_breath_detector.sv
// Wind breath detector.
// Request channel (req_valid/req_ready, req_raw_wind): one 10-bit ADC sample
// per request. Response channel (rsp_valid/rsp_ready): one response per
// request carrying the rest/breath flag, a begin/end event code, the
// band-pass value (fast minus slow average) and the saturated window sum.
// Control registers are written through csr_we/csr_addr/csr_wdata, one per
// cycle; the user must do so only while no request is in flight (unchecked).
// Path: an accepted request is registered into the second stage, then into the
// output register. Throughput: one request per cycle while rsp_ready is high.
// The averages update in the accept cycle (a 26x16 and a 10x17 multiply each); the
// second stage reads the history ring, a synchronous memory of HIST_LEN
// entries, and keeps a running window sum (subtract the oldest entry, add the
// new one), so the sum never sweeps the ring.
// Reset: averages, previous band-pass, window sum, ring pointer and flag go
// to zero, registers to their defaults; the ring is cleared at once by
// per-entry valid bits, so no clearing pass is needed.
// Stall: when rsp_ready is low the response holds, the second stage holds
// one more request, and req_ready then drops until the output drains.
`default_nettype none

module wind_breath_detector
   import wbd_pkg::*;
#(
   parameter int HIST_LEN = 16
)
(
   input  wire logic                  clock,
   input  wire logic                  reset,

   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [RAW_W-1:0]      req_raw_wind,

   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_breathing,
   output logic [EVENT_W-1:0]         rsp_event_res,
   output logic signed [BP_W-1:0]     rsp_bandpass,
   output logic signed [WSUM_W-1:0]   rsp_window_sum,

   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_addr,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int POS_W = $clog2(HIST_LEN);
   // Window sum needs room for HIST_LEN entries of DIFF_W bits
   localparam int SUM_W = DIFF_W + $clog2(HIST_LEN);
   localparam int CMP_W = (SUM_W > THRESH_W) ? SUM_W : THRESH_W;
   localparam logic signed [CMP_W-1:0] SAT_MAX = CMP_W'(32767);
   localparam logic signed [CMP_W-1:0] SAT_MIN = CMP_W'(-32768);
   localparam logic [POS_W-1:0]        POS_LAST = POS_W'(HIST_LEN - 1);

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   logic [FACTOR_W-1:0]        slow_factor_ff;
   logic [FACTOR_W-1:0]        fast_factor_ff;
   logic signed [THRESH_W-1:0] start_thr_ff;
   logic signed [THRESH_W-1:0] end_thr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_factor_ff <= SLOW_FACTOR_RST;
         fast_factor_ff <= FAST_FACTOR_RST;
         start_thr_ff   <= START_THRESHOLD_RST;
         end_thr_ff     <= END_THRESHOLD_RST;
      end else if (csr_we) begin
         case (csr_addr)
            CSR_SLOW_FACTOR:     slow_factor_ff <= csr_wdata;
            CSR_FAST_FACTOR:     fast_factor_ff <= csr_wdata;
            CSR_START_THRESHOLD: start_thr_ff   <= csr_wdata;
            CSR_END_THRESHOLD:   end_thr_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Handshake: output register, second stage, accept
   // ---------------------------------------------------------------------
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_vld_ff, s1_vld_in;
   logic out_open;
   logic s1_adv;
   logic accept;

   // Output register can load when empty or being drained this cycle
   assign out_open  = !rsp_valid_ff || rsp_ready;
   assign s1_adv    = s1_vld_ff && out_open;
   assign req_ready = !s1_vld_ff || out_open;
   assign accept    = req_valid && req_ready;

   assign s1_vld_in    = accept ? 1'b1 : (s1_adv ? 1'b0 : s1_vld_ff);
   assign rsp_valid_in = s1_adv ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_vld_ff    <= s1_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // ---------------------------------------------------------------------
   // Stage 0: update both averages on accept. The average registers also
   // serve as the second stage's operands: they only change on accept, and
   // no accept happens while the second stage holds.
   // ---------------------------------------------------------------------
   logic [AVG_W-1:0] slow_avg_ff, slow_avg_in;
   logic [AVG_W-1:0] fast_avg_ff, fast_avg_in;

   wbd_ema u_slow_ema (
      .avg      (slow_avg_ff),
      .factor   (slow_factor_ff),
      .raw      (req_raw_wind),
      .avg_next (slow_avg_in)
   );

   wbd_ema u_fast_ema (
      .avg      (fast_avg_ff),
      .factor   (fast_factor_ff),
      .raw      (req_raw_wind),
      .avg_next (fast_avg_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         slow_avg_ff <= '0;
         fast_avg_ff <= '0;
      end else if (accept) begin
         slow_avg_ff <= slow_avg_in;
         fast_avg_ff <= fast_avg_in;
      end
   end

   // ---------------------------------------------------------------------
   // History ring: synchronous memory, read on accept at the next slot
   // (the oldest entry), written when the second stage advances. The read
   // of one request and the write of the one ahead always hit different
   // slots, provided HIST_LEN is at least two.
   // ---------------------------------------------------------------------
   logic [POS_W-1:0]               pos_ff, pos_in;
   logic [POS_W-1:0]               wr_pos_ff;
   logic signed [DIFF_W-1:0]       ring_mem [HIST_LEN];
   logic [HIST_LEN-1:0]            ring_vld_ff;
   logic signed [DIFF_W-1:0]       rd_data_ff;
   logic                           rd_vld_ff;
   logic signed [DIFF_W-1:0]       diff;

   assign pos_in = (pos_ff == POS_LAST) ? '0 : pos_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else if (accept) begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         wr_pos_ff  <= pos_ff;
         rd_data_ff <= ring_mem[pos_ff];
         rd_vld_ff  <= ring_vld_ff[pos_ff];
      end
      if (s1_adv) begin
         ring_mem[wr_pos_ff] <= diff;
      end
   end

   // An entry never written reads as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         ring_vld_ff <= '0;
      end else if (s1_adv) begin
         ring_vld_ff[wr_pos_ff] <= 1'b1;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 1: band-pass, difference, running sum, hysteresis
   // ---------------------------------------------------------------------
   logic signed [AVG_W:0]      delta;
   logic [AVG_W:0]             delta_mag;
   logic [BP_W-1:0]            bp_mag;
   logic signed [BP_W-1:0]     bp;
   logic signed [BP_W-1:0]     prev_bp_ff;
   logic signed [DIFF_W-1:0]   oldest;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic signed [CMP_W-1:0]    sum_cmp;
   logic signed [CMP_W-1:0]    start_cmp;
   logic signed [CMP_W-1:0]    end_cmp;
   logic signed [WSUM_W-1:0]   sum_sat;
   logic                       flag_ff, flag_in;
   event_type                  event_code;

   assign delta     = $signed({1'b0, fast_avg_ff}) - $signed({1'b0, slow_avg_ff});
   assign delta_mag = delta[AVG_W] ? (AVG_W+1)'(-delta) : delta;
   // Truncate toward zero: drop the fraction of the magnitude
   assign bp_mag    = {1'b0, delta_mag[AVG_W-1:FRAC_W]};
   assign bp        = delta[AVG_W] ? $signed(-bp_mag) : $signed(bp_mag);
   assign diff      = DIFF_W'(bp) - DIFF_W'(prev_bp_ff);

   assign oldest    = rd_vld_ff ? rd_data_ff : '0;
   assign sum_in    = sum_ff - SUM_W'(oldest) + SUM_W'(diff);

   assign sum_cmp   = CMP_W'(sum_in);
   assign start_cmp = CMP_W'(start_thr_ff);
   assign end_cmp   = CMP_W'(end_thr_ff);

   // Only the condition of the present state is checked
   always_comb begin
      flag_in    = flag_ff;
      event_code = EV_NONE;
      if (!flag_ff && (sum_cmp < start_cmp)) begin
         flag_in    = 1'b1;
         event_code = EV_BEGIN;
      end else if (flag_ff && (sum_cmp > end_cmp)) begin
         flag_in    = 1'b0;
         event_code = EV_END;
      end
   end

   always_comb begin
      if (sum_cmp > SAT_MAX) begin
         sum_sat = SAT_MAX[WSUM_W-1:0];
      end else if (sum_cmp < SAT_MIN) begin
         sum_sat = SAT_MIN[WSUM_W-1:0];
      end else begin
         sum_sat = sum_cmp[WSUM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_bp_ff <= '0;
         sum_ff     <= '0;
         flag_ff    <= 1'b0;
      end else if (s1_adv) begin
         prev_bp_ff <= bp;
         sum_ff     <= sum_in;
         flag_ff    <= flag_in;
      end
   end

   // Response payload: load on advance, hold while stalled
   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_breathing  <= flag_in;
         rsp_event_res  <= event_code;
         rsp_bandpass   <= bp;
         rsp_window_sum <= sum_sat;
      end
   end

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   a_event_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_event_res == EV_NONE || rsp_event_res == EV_BEGIN ||
                     rsp_event_res == EV_END))
      else $error("undefined event code on response");

   a_begin_sets_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_BEGIN) |-> rsp_breathing)
      else $error("breath begin without breath flag");

   a_end_clears_flag: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_event_res == EV_END) |-> !rsp_breathing)
      else $error("breath end with breath flag still set");

   a_flag_moves_with_event: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (flag_ff != $past(flag_ff)) == (rsp_event_res != EV_NONE))
      else $error("flag changed without event, or event without change");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      (s1_vld_ff && !out_open) |=> (s1_vld_ff && $stable(wr_pos_ff)))
      else $error("second stage dropped a stalled request");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff <= POS_LAST) && (wr_pos_ff <= POS_LAST || !s1_vld_ff))
      else $error("ring pointer out of range");

endmodule

`default_nettype wire
